[design/swr_pkg.sv]
// Shared types and constants for the sample-without-replacement block.
package swr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CFG_W         = 7;
    localparam int INDEX_W       = 6;
    localparam int STATUS_W      = 2;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int REG_IDX_W     = APB_ADDR_W - 2;

    // Item operations
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_DRAW    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DRAWN     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RESTART   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_POOL_SIZE  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_PICK_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] POOL_SIZE_RESET  = 7'd64;
    localparam logic [CFG_W-1:0] PICK_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic                     op;
        logic [FRACTION_BITS-1:0] random_fraction;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] pool_size;
        logic [CFG_W-1:0] pick_count;
    } cfg_t;

endpackage

[design/swr_cfg.sv]
// APB register file holding pool_size and pick_count.
module swr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output swr_pkg::cfg_t                  cfg
);
    import swr_pkg::*;

    logic [CFG_W-1:0]     pool_size_reg;
    logic [CFG_W-1:0]     pool_size_next;
    logic [CFG_W-1:0]     pick_count_reg;
    logic [CFG_W-1:0]     pick_count_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        pool_size_next  = pool_size_reg;
        pick_count_next = pick_count_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_POOL_SIZE:  pool_size_next  = pwdata[CFG_W-1:0];
                REG_PICK_COUNT: pick_count_next = pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POOL_SIZE:  prdata = APB_DATA_W'(pool_size_reg);
            REG_PICK_COUNT: prdata = APB_DATA_W'(pick_count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg  <= POOL_SIZE_RESET;
            pick_count_reg <= PICK_COUNT_RESET;
        end
        else
        begin
            pool_size_reg  <= pool_size_next;
            pick_count_reg <= pick_count_next;
        end
    end

    assign cfg.pool_size  = pool_size_reg;
    assign cfg.pick_count = pick_count_reg;

endmodule

[design/swr_map.sv]
// Used-index bitmap: one flop per pool entry, single-bit read and set.
module swr_map #(
    parameter int MAX_POOL = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        set,
    input  logic [$clog2(MAX_POOL)-1:0] idx,
    output logic                        used
);
    import swr_pkg::*;

    logic [MAX_POOL-1:0] map_reg;
    logic [MAX_POOL-1:0] map_next;

    always_comb
    begin
        map_next = map_reg;
        if (clear)
        begin
            map_next = '0;
        end
        else if (set)
        begin
            map_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    assign used = map_reg[idx];

endmodule

[design/sample_without_replacement.sv]
// Top level: sequencer that draws distinct pool indices without replacement.
//
// Usage: drive a word on item and raise start while busy is low; the word is
// taken at that clock edge. A restart word (op = 0) clears the used map and
// the pick counter and answers in the next cycle with status 1. A draw word
// (op = 1) scales random_fraction by the number of unused entries to get a
// rank, finds the unused entry of that rank counting up from index 0, marks
// it used and returns it with status 0; last is set on the draw that
// completes the round. A draw once the round is complete (or the pool is
// empty) returns status 2 with index 0 and changes nothing. Every word gives
// exactly one result, shown on result for one cycle while done is high; the
// receiver cannot stall it, so capture it in that cycle. A draw first counts
// the free entries of the effective pool, then forms the rank, then walks
// the map from index 0 up to the chosen entry; both passes go through the
// map one bit per cycle on a single shared counter. busy drops in the cycle
// that done is shown, so a new word may be started then. pool_size and
// pick_count sit on the APB port at byte addresses 0 and 4; write them only
// while the block is idle.
module sample_without_replacement #(
    parameter int MAX_POOL = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  swr_pkg::in_t                   item,
    output logic                           done,
    output swr_pkg::out_t                  result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import swr_pkg::*;

    // Counter widths: PW holds 0..MAX_POOL, IW addresses the map,
    // CW is wide enough for both the counters and the config fields.
    localparam int PW     = $clog2(MAX_POOL + 1);
    localparam int IW     = $clog2(MAX_POOL);
    localparam int CW     = (PW > CFG_W) ? PW : CFG_W;
    localparam int PROD_W = FRACTION_BITS + PW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COUNT = 2'd1;
    localparam logic [1:0] S_RANK  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    cfg_t cfg;

    logic [1:0]               state_reg,     state_next;
    logic [PW-1:0]            j_reg,         j_next;
    logic [PW-1:0]            remaining_reg, remaining_next;
    logic [PW-1:0]            cnt_reg,       cnt_next;
    logic [PW-1:0]            rank_reg,      rank_next;
    logic [FRACTION_BITS-1:0] frac_reg,      frac_next;
    logic [CFG_W-1:0]         picks_reg,     picks_next;
    logic                     done_reg,      done_next;
    out_t                     result_reg,    result_next;

    logic              map_clear;
    logic              map_set;
    logic              map_used;

    logic [CW-1:0]     pool_cw;
    logic [CW-1:0]     pick_cw;
    logic [CW-1:0]     n_cw;
    logic [CW-1:0]     target_cw;
    logic [CW-1:0]     j_cw;
    logic [CW-1:0]     picks_cw;
    logic              scan_end;
    logic              round_full;
    logic [PROD_W-1:0] product;
    logic              accept;

    swr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swr_map #(
        .MAX_POOL (MAX_POOL)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (map_clear),
        .set   (map_set),
        .idx   (j_reg[IW-1:0]),
        .used  (map_used)
    );

    // Effective pool is pool_size clamped to MAX_POOL; the round target is
    // the smaller of pick_count and that pool.
    assign pool_cw    = CW'(cfg.pool_size);
    assign pick_cw    = CW'(cfg.pick_count);
    assign n_cw       = (pool_cw > CW'(MAX_POOL)) ? CW'(MAX_POOL) : pool_cw;
    assign target_cw  = (pick_cw < n_cw) ? pick_cw : n_cw;
    assign j_cw       = CW'(j_reg);
    assign picks_cw   = CW'(picks_reg);
    assign scan_end   = (j_cw == n_cw);
    assign round_full = (picks_cw >= target_cw);

    // Rank = floor(u * remaining): one narrow multiply, registered in rank_reg.
    assign product = PROD_W'(frac_reg) * PROD_W'(remaining_reg);

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        remaining_next = remaining_reg;
        cnt_next       = cnt_reg;
        rank_next      = rank_reg;
        frac_next      = frac_reg;
        picks_next     = picks_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        map_clear      = 1'b0;
        map_set        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_RESTART)
                    begin
                        // Drop the round and answer next cycle.
                        map_clear          = 1'b1;
                        picks_next         = '0;
                        done_next          = 1'b1;
                        result_next.index  = '0;
                        result_next.status = ST_RESTART;
                        result_next.last   = 1'b0;
                    end
                    else
                    begin
                        frac_next      = item.random_fraction;
                        j_next         = '0;
                        remaining_next = '0;
                        state_next     = S_COUNT;
                    end
                end
            end

            S_COUNT:
            begin
                // Count free entries of the current pool, one bit a cycle.
                if (scan_end)
                begin
                    state_next = S_RANK;
                end
                else
                begin
                    if (!map_used)
                    begin
                        remaining_next = remaining_reg + 1'b1;
                    end
                    j_next = j_reg + 1'b1;
                end
            end

            S_RANK:
            begin
                if (round_full || remaining_reg == '0)
                begin
                    done_next          = 1'b1;
                    result_next.index  = '0;
                    result_next.status = ST_EXHAUSTED;
                    result_next.last   = 1'b0;
                    state_next         = S_IDLE;
                end
                else
                begin
                    rank_next  = product[PROD_W-1:FRACTION_BITS];
                    j_next     = '0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (scan_end)
                begin
                    // Unreachable since rank < remaining; report exhausted.
                    done_next          = 1'b1;
                    result_next.index  = '0;
                    result_next.status = ST_EXHAUSTED;
                    result_next.last   = 1'b0;
                    state_next         = S_IDLE;
                end
                else if (!map_used && cnt_reg == rank_reg)
                begin
                    // Mark the entry and return it.
                    map_set            = 1'b1;
                    picks_next         = picks_reg + 1'b1;
                    done_next          = 1'b1;
                    result_next.index  = j_cw[INDEX_W-1:0];
                    result_next.status = ST_DRAWN;
                    result_next.last   = ((picks_cw + 1'b1) >= target_cw)
                                         || (remaining_reg == PW'(1));
                    state_next         = S_IDLE;
                end
                else
                begin
                    if (!map_used)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    j_next = j_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            remaining_reg <= '0;
            cnt_reg       <= '0;
            picks_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            remaining_reg <= remaining_next;
            cnt_reg       <= cnt_next;
            picks_reg     <= picks_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        frac_reg   <= frac_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A hit during the scan must produce a drawn result on the next cycle.
    a_hit_gives_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !scan_end && !map_used && cnt_reg == rank_reg)
        |=> (done && result.status == ST_DRAWN))
        else $error("scan hit did not return a drawn index");

    // The free-entry counter of the scan never passes the rank.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= rank_reg && rank_reg < remaining_reg))
        else $error("scan counter passed the rank");

    // The free count never exceeds the effective pool.
    a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RANK) |-> (CW'(remaining_reg) <= n_cw))
        else $error("free count larger than pool");

    // A drawn result always follows a counted pick.
    a_draw_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_DRAWN) |-> (picks_reg != '0))
        else $error("drawn result without a pick counted");

endmodule

[verif/tb_sample_without_replacement.sv]
// Self-checking testbench for the sample-without-replacement block.
//
// Drive restart and draw words through the start/busy handshake and write
// pool_size and pick_count over APB while the block is idle. Each accepted
// word goes through a local model of the block: a used map, a draw counter
// and the two register values. The model produces one expected result word,
// which is queued. A monitor takes every result word in the cycle that done
// marks, and compares it field by field with the oldest queued word.
// Stimulus: a short directed run over the corner cases, then rounds of
// random draws under several sender idle rates and register settings.
module tb_sample_without_replacement;

    import swr_pkg::*;

    localparam int MAX_POOL     = 64;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    // Leave room for the longest draw and for long gaps.
    localparam int DRAW_CYCLES  = 2 * MAX_POOL + 3;
    localparam int LIMIT_CYCLES = 2_000_000;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    in_t                   item    = '0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic                  busy;
    logic                  done;
    out_t                  result;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sample_without_replacement #(
        .MAX_POOL(MAX_POOL)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Model state: mirrors the block's used map, draw counter and registers.
    logic [MAX_POOL-1:0] taken_map   = '0;
    int unsigned         draws_taken = 0;
    logic [CFG_W-1:0]    pool_reg    = POOL_SIZE_RESET;
    logic [CFG_W-1:0]    picks_reg   = PICK_COUNT_RESET;

    out_t expected_draws[$];
    out_t want;

    int fail_count     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int drawn_count    = 0;
    int exhaust_count  = 0;
    int restart_count  = 0;
    int reg_writes     = 0;
    int sender_idle    = 0;

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("timeout: %0d result words still pending", expected_draws.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Pool sizes above MAX_POOL count as MAX_POOL.
    function automatic int unsigned pool_in_use();
        return (pool_reg > MAX_POOL) ? MAX_POOL : pool_reg;
    endfunction

    // Work out the result of one word and advance the model state.
    function automatic out_t draw_index(in_t w);
        out_t        r;
        int unsigned n;
        int unsigned target;
        int unsigned free_cnt;
        int unsigned rank;
        int unsigned seen;
        r = '0;
        if (w.op == OP_RESTART) begin
            taken_map   = '0;
            draws_taken = 0;
            r.status    = ST_RESTART;
            return r;
        end
        n        = pool_in_use();
        target   = (picks_reg < n) ? picks_reg : n;
        free_cnt = 0;
        for (int j = 0; j < n; j++)
            if (!taken_map[j])
                free_cnt++;
        r.status = ST_EXHAUSTED;
        // Round complete or nothing left: report exhausted, touch nothing.
        if (draws_taken >= target || free_cnt == 0)
            return r;
        rank = (longint'(w.random_fraction) * free_cnt) >> FRACTION_BITS;
        seen = 0;
        for (int j = 0; j < n; j++) begin
            if (!taken_map[j]) begin
                if (seen == rank) begin
                    taken_map[j] = 1'b1;
                    draws_taken++;
                    r.index  = j[INDEX_W-1:0];
                    r.status = ST_DRAWN;
                    // Last on reaching the target or on taking the final free entry.
                    r.last   = (draws_taken >= target || free_cnt == 1);
                    return r;
                end
                seen++;
            end
        end
        return r;
    endfunction

    // Take each result word in its one done cycle and check it.
    always @(posedge clk) begin
        if (done === 1'b1) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result word: index=%0d status=%0d last=%0d",
                       result.index, result.status, result.last);
                fail_count++;
            end
            else begin
                want = expected_draws.pop_front();
                results_seen++;
                if (result.index !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, result.index);
                    fail_count++;
                end
                if (result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // Send one word. Leave start high on return so a word that follows at
    // once keeps it high; anything else must drop start first.
    task automatic send_word(input in_t w);
        out_t r;
        int   gap;
        gap = 0;
        while (sender_idle != 0 && $urandom_range(99) < sender_idle)
            gap++;
        // Now and then idle across a whole draw so gaps land on every phase.
        if (sender_idle != 0 && $urandom_range(7) == 0)
            gap += $urandom_range(0, 2 * pool_in_use() + 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        r = draw_index(w);
        expected_draws.push_back(r);
        words_sent++;
        case (r.status)
            ST_DRAWN:   drawn_count++;
            ST_RESTART: restart_count++;
            default:    exhaust_count++;
        endcase
    endtask

    // Drop start and hold until every queued result word has come back.
    task automatic drain();
        start <= 1'b0;
        while (expected_draws.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] reg_idx,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_POOL_SIZE)
            pool_reg = data[CFG_W-1:0];
        else if (reg_idx == REG_PICK_COUNT)
            picks_reg = data[CFG_W-1:0];
        reg_writes++;
    endtask

    // Write both registers once the block is idle; junk in the upper bits
    // must be dropped by the block.
    task automatic set_config(input int pool, input int picks);
        logic [APB_DATA_W-1:0] junk;
        drain();
        junk = $urandom;
        apb_write(REG_POOL_SIZE, {junk[APB_DATA_W-1:CFG_W], pool[CFG_W-1:0]});
        // Hold the bus idle before the next setup phase.
        @(posedge clk);
        junk = $urandom;
        apb_write(REG_PICK_COUNT, {junk[APB_DATA_W-1:CFG_W], picks[CFG_W-1:0]});
    endtask

    task automatic draw(input logic [FRACTION_BITS-1:0] u);
        send_word(in_t'{OP_DRAW, u});
    endtask

    task automatic restart();
        send_word(in_t'{OP_RESTART, FRACTION_BITS'($urandom)});
    endtask

    // Draw straight out of reset, then the fraction extremes on a full pool.
    task automatic test_reset_state();
        draw(16'h0000);
        draw(16'hFFFF);
        draw(16'h8000);
        restart();
    endtask

    // More picks than pool: the pool running dry ends the round.
    task automatic test_short_pool();
        set_config(3, 5);
        restart();
        draw(16'hFFFF);
        draw(16'h0000);
        draw(16'h5555);
        draw(16'hFFFF);
    endtask

    // Oversized pool clamps to MAX_POOL; the pick count ends the round.
    task automatic test_oversize_pool();
        set_config(127, 2);
        restart();
        draw(16'hFFFF);
        draw(16'hAAAA);
        draw(16'h0001);
    endtask

    // Empty pool and zero picks: every draw reports exhausted.
    task automatic test_empty_cases();
        set_config(0, 64);
        draw(16'h4000);
        restart();
        set_config(5, 0);
        draw(16'hC000);
    endtask

    // Shrink and regrow the pool in mid-round; used bits above it are ignored.
    task automatic test_resize_mid_round();
        set_config(8, 8);
        restart();
        draw(16'hFFFF);
        draw(16'h0000);
        set_config(4, 8);
        draw(16'hFFFF);
        draw(16'h0000);
        set_config(8, 8);
        draw(16'h8000);
    endtask

    // One-entry pool: the first draw is last, the next is exhausted.
    task automatic test_single_entry();
        set_config(1, 1);
        restart();
        draw(16'h1234);
        draw(16'hFFFF);
    endtask

    // Pick a setting: mostly small pools, a few full or out-of-range ones.
    task automatic random_config();
        int pool;
        int picks;
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            pool = $urandom_range(1, 12);
        else if (sel < 75)
            pool = $urandom_range(13, 63);
        else if (sel < 85)
            pool = MAX_POOL;
        else
            case ($urandom_range(2))
                0:       pool = 0;
                1:       pool = 127;
                default: pool = $urandom_range(MAX_POOL + 1, 127);
            endcase
        sel = $urandom_range(99);
        if (sel < 50)
            picks = pool;
        else if (sel < 80)
            picks = $urandom_range(1, (pool < 1) ? 1 : ((pool > MAX_POOL) ? MAX_POOL : pool));
        else
            picks = $urandom_range(0, 127);
        set_config(pool, picks);
    endtask

    // Rounds of restart plus draws with random fractions, run a little past
    // the target; some rounds are cut short or carry a stray word.
    task automatic test_random_rounds(input int idle_pct, input int n_words);
        int          sent;
        int unsigned n;
        int unsigned target;
        int          draws;
        logic [FRACTION_BITS-1:0] u;
        sender_idle = idle_pct;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(2) == 0)
                random_config();
            else if ($urandom_range(9) == 0)
                drain();
            if ($urandom_range(9) != 0) begin
                restart();
                sent++;
            end
            n      = pool_in_use();
            target = (picks_reg < n) ? picks_reg : n;
            if ($urandom_range(6) == 0)
                draws = $urandom_range(1, (target < 1) ? 1 : target);
            else
                draws = target + $urandom_range(0, 2);
            repeat (draws) begin
                case ($urandom_range(19))
                    0:       u = 16'h0000;
                    1:       u = 16'hFFFF;
                    default: u = $urandom_range(0, 16'hFFFF);
                endcase
                if ($urandom_range(24) == 0)
                    send_word(in_t'{logic'($urandom_range(1)), u});
                else
                    draw(u);
                sent++;
            end
        end
        sender_idle = 0;
    endtask

    initial begin : main_seq
        int guard;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_short_pool();
        test_oversize_pool();
        test_empty_cases();
        test_resize_mid_round();
        test_single_entry();

        // Idle phases; the receiver side cannot stall, so only the sender idles.
        test_random_rounds(0, 115);
        test_random_rounds(46, 115);
        test_random_rounds(34, 115);
        set_config(MAX_POOL, MAX_POOL);
        test_random_rounds(0, 105);

        // Drop start, wait out the queue with a limit, then the tail.
        start <= 1'b0;
        guard = 0;
        while (expected_draws.size() != 0 && guard < 4 * DRAW_CYCLES) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAW_CYCLES) @(posedge clk);
        if (expected_draws.size() != 0) begin
            $error("%0d expected result words never arrived", expected_draws.size());
            fail_count++;
        end

        $display("covered %0d words: %0d draws, %0d exhausted, %0d restarts",
                 words_sent, drawn_count, exhaust_count, restart_count);
        $display("checked %0d result words over %0d register writes",
                 results_seen, reg_writes);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
